// ===== hdl/arpnc_pkg.sv =====
// Shared types and constants for the ARP neighbor cache responder.
// No dependencies.
package arpnc_pkg;
	localparam int TableEntries = 16;
	localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int CntW = $clog2(TableEntries + 1);

	localparam logic [1:0] MODE_PKT = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [3:0] ST_RECORDED = 4'd0;
	localparam logic [3:0] ST_REPLY = 4'd1;
	localparam logic [3:0] ST_BAD_ETH = 4'd2;
	localparam logic [3:0] ST_BAD_HW = 4'd3;
	localparam logic [3:0] ST_BAD_PROTO = 4'd4;
	localparam logic [3:0] ST_BAD_HWSZ = 4'd5;
	localparam logic [3:0] ST_BAD_PRSZ = 4'd6;
	localparam logic [3:0] ST_HIT = 4'd7;
	localparam logic [3:0] ST_MISS = 4'd8;
	localparam logic [3:0] ST_TICK = 4'd9;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_REQUEST = 2'd1;
	localparam logic [1:0] OP_REPLY = 2'd2;

	localparam logic [2:0] REG_MAC = 3'd0;
	localparam logic [2:0] REG_IP_A = 3'd1;
	localparam logic [2:0] REG_IP_B = 3'd2;
	localparam logic [2:0] REG_IP_CNT = 3'd3;
	localparam logic [2:0] REG_TIMEOUT = 3'd4;

	localparam logic [15:0] ETH_ARP = 16'h0806;
	localparam logic [15:0] HW_ETH = 16'h0001;
	localparam logic [15:0] PROTO_IP4 = 16'h0800;
	localparam logic [7:0] HW_LEN = 8'd6;
	localparam logic [7:0] PROTO_LEN = 8'd4;
	localparam logic [15:0] ARP_REQ = 16'h0001;

	typedef struct packed {
		logic [3:0] status;
		logic [1:0] send_opcode;
		logic [31:0] send_sender_ip;
		logic [47:0] send_target_mac;
		logic [31:0] send_target_ip;
		logic [47:0] found_mac;
		logic [4:0] purged_count;
		logic table_full_drop;
		logic last;
	} result_t;
endpackage

// ===== hdl/arp_neighbor_cache_responder_core.sv =====
// ARP neighbor cache responder top level: table walk sequencer and storage.
// Depends on arpnc_pkg and arpnc_outq.
//
// Usage: one input request channel (in_valid/in_ready) carries a received
// ARP packet, a tick or a lookup, chosen by mode. Results leave on the output
// channel (out_valid/out_ready), one or two per request, none for an unused
// mode; last marks the final one. Configuration writes use cfg_valid/cfg_ready
// with cfg_index/cfg_data and are always ready.
// Rate: the sequencer walks the table one entry per cycle using one shared IP
// comparator. A lookup or tick walks the table and passes through done; a
// packet passes through match walk, free-slot walk, write, two reply slots and
// done, skipping the free-slot walk when the sender is found. A packet rejected
// on its header queues its result on acceptance and walks nothing; an unused
// mode passes only through done.
// One request is in flight at a time; in_ready is low while it is processed
// and until the result queue is empty.
// Reset clears the valid bits and returns configuration to its defaults; entry
// contents are left undefined and are never read while invalid. If the receiver
// stalls, the two-entry result queue holds the results and no new request is taken.
module arp_neighbor_cache_responder_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] mode,
	input logic [15:0] ethertype,
	input logic [15:0] hw_type,
	input logic [15:0] ptype,
	input logic [7:0] hw_size,
	input logic [7:0] proto_size,
	input logic [15:0] opcode,
	input logic [47:0] src_mac,
	input logic [31:0] src_ip,
	input logic [31:0] tgt_ip,
	input logic [31:0] lookup_ip,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] status,
	output logic [1:0] send_opcode,
	output logic [31:0] send_sender_ip,
	output logic [47:0] send_target_mac,
	output logic [31:0] send_target_ip,
	output logic [47:0] found_mac,
	output logic [4:0] purged_count,
	output logic table_full_drop,
	output logic last
);
	localparam int IW = arpnc_pkg::IdxW;
	localparam int CW = arpnc_pkg::CntW;
	localparam logic [CW-1:0] LastIdx = CW'(arpnc_pkg::TableEntries - 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MATCH = 7'b0000010,
		S_FREE = 7'b0000100,
		S_WRITE = 7'b0001000,
		S_REPLY_A = 7'b0010000,
		S_REPLY_B = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	logic [47:0] local_mac_q;
	logic [31:0] local_ip_a_q, local_ip_b_q;
	logic [1:0] ip_cnt_q;
	logic [15:0] timeout_q;

	// table storage
	logic [arpnc_pkg::TableEntries-1:0] valid_q;
	logic [31:0] ip_mem [arpnc_pkg::TableEntries];
	logic [47:0] mac_mem [arpnc_pkg::TableEntries];
	logic [15:0] ttl_mem [arpnc_pkg::TableEntries];

	logic [1:0] mode_q;
	logic [47:0] smac_q;
	logic [31:0] sip_q, tip_q, key_q;
	logic is_req_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] slot_q;
	logic slot_ok_q, replied_q;
	logic [4:0] purged_q;

	logic [IW-1:0] idx;
	logic ip_eq;
	logic push;
	arpnc_pkg::result_t res, q_out;
	logic [1:0] q_cnt;
	logic [1:0] nloc;
	logic rep_a, rep_b;

	assign idx = idx_q[IW-1:0];
	// shared comparator
	assign ip_eq = valid_q[idx] && (ip_mem[idx] == key_q);
	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE) && (q_cnt == 2'd0);
	assign nloc = (ip_cnt_q > 2'd2) ? 2'd2 : ip_cnt_q;
	assign rep_a = is_req_q && (nloc >= 2'd1) && (local_ip_a_q == tip_q);
	assign rep_b = is_req_q && (nloc == 2'd2) && (local_ip_b_q == tip_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_mac_q <= '0;
			local_ip_a_q <= '0;
			local_ip_b_q <= '0;
			ip_cnt_q <= 2'd1;
			timeout_q <= 16'd60;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				arpnc_pkg::REG_MAC: local_mac_q <= cfg_data;
				arpnc_pkg::REG_IP_A: local_ip_a_q <= cfg_data[31:0];
				arpnc_pkg::REG_IP_B: local_ip_b_q <= cfg_data[31:0];
				arpnc_pkg::REG_IP_CNT: ip_cnt_q <= cfg_data[1:0];
				arpnc_pkg::REG_TIMEOUT: timeout_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// result formation
	always_comb begin
		res = '0;
		push = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready && mode == arpnc_pkg::MODE_PKT) begin
					res.last = 1'b1;
					if (ethertype != arpnc_pkg::ETH_ARP) begin
						res.status = arpnc_pkg::ST_BAD_ETH; push = 1'b1;
					end else if (hw_type != arpnc_pkg::HW_ETH) begin
						res.status = arpnc_pkg::ST_BAD_HW; push = 1'b1;
					end else if (ptype != arpnc_pkg::PROTO_IP4) begin
						res.status = arpnc_pkg::ST_BAD_PROTO; push = 1'b1;
					end else if (hw_size != arpnc_pkg::HW_LEN) begin
						res.status = arpnc_pkg::ST_BAD_HWSZ; push = 1'b1;
					end else if (proto_size != arpnc_pkg::PROTO_LEN) begin
						res.status = arpnc_pkg::ST_BAD_PRSZ; push = 1'b1;
					end
				end
			end
			S_MATCH: begin
				if (mode_q == arpnc_pkg::MODE_TICK && idx_q == LastIdx) begin
					res.status = arpnc_pkg::ST_TICK;
					res.purged_count = purged_q
						+ 5'(valid_q[idx] && ttl_mem[idx] == 16'd0);
					res.last = 1'b1;
					push = 1'b1;
				end else if (mode_q == arpnc_pkg::MODE_LOOKUP
						&& (ip_eq || idx_q == LastIdx)) begin
					res.last = 1'b1;
					push = 1'b1;
					if (ip_eq) begin
						res.status = arpnc_pkg::ST_HIT;
						res.found_mac = mac_mem[idx];
					end else begin
						res.status = arpnc_pkg::ST_MISS;
						res.send_opcode = arpnc_pkg::OP_REQUEST;
						res.send_sender_ip = local_ip_a_q;
						res.send_target_mac = '1;
						res.send_target_ip = key_q;
					end
				end
			end
			S_REPLY_A: begin
				res.table_full_drop = ~slot_ok_q;
				if (rep_a) begin
					res.status = arpnc_pkg::ST_REPLY;
					res.send_opcode = arpnc_pkg::OP_REPLY;
					res.send_sender_ip = local_ip_a_q;
					res.send_target_mac = smac_q;
					res.send_target_ip = sip_q;
					res.last = ~rep_b;
					push = 1'b1;
				end
			end
			S_REPLY_B: begin
				res.table_full_drop = ~slot_ok_q;
				res.last = 1'b1;
				push = 1'b1;
				if (rep_b) begin
					res.status = arpnc_pkg::ST_REPLY;
					res.send_opcode = arpnc_pkg::OP_REPLY;
					res.send_sender_ip = local_ip_b_q;
					res.send_target_mac = smac_q;
					res.send_target_ip = sip_q;
				end else if (replied_q) begin
					push = 1'b0;
				end else begin
					res.status = arpnc_pkg::ST_RECORDED;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WRITE && slot_ok_q) begin
			ip_mem[slot_q] <= sip_q;
			mac_mem[slot_q] <= smac_q;
			ttl_mem[slot_q] <= timeout_q;
		end else if (state_q == S_MATCH && mode_q == arpnc_pkg::MODE_TICK
				&& valid_q[idx] && ttl_mem[idx] != 16'd0) begin
			ttl_mem[idx] <= ttl_mem[idx] - 16'd1;
		end
		if (in_valid && in_ready) begin
			mode_q <= mode;
			smac_q <= src_mac;
			sip_q <= src_ip;
			tip_q <= tgt_ip;
			key_q <= (mode == arpnc_pkg::MODE_LOOKUP) ? lookup_ip : src_ip;
			is_req_q <= opcode == arpnc_pkg::ARP_REQ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			idx_q <= '0;
			slot_q <= '0;
			slot_ok_q <= 1'b0;
			replied_q <= 1'b0;
			purged_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					purged_q <= '0;
					slot_ok_q <= 1'b0;
					replied_q <= 1'b0;
					// unused mode passes through done so in_ready drops for a cycle
					if (in_valid && in_ready && !push)
						state_q <= (mode == arpnc_pkg::MODE_NONE) ? S_DONE : S_MATCH;
				end
				S_MATCH: begin
					if (mode_q == arpnc_pkg::MODE_TICK) begin
						if (valid_q[idx] && ttl_mem[idx] == 16'd0) begin
							valid_q[idx] <= 1'b0;
							purged_q <= purged_q + 5'd1;
						end
						idx_q <= idx_q + CW'(1);
						if (idx_q == LastIdx) state_q <= S_DONE;
					end else if (mode_q == arpnc_pkg::MODE_LOOKUP) begin
						idx_q <= idx_q + CW'(1);
						if (push) state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
						if (ip_eq) begin
							slot_q <= idx;
							slot_ok_q <= 1'b1;
							state_q <= S_WRITE;
						end else if (idx_q == LastIdx) begin
							idx_q <= '0;
							state_q <= S_FREE;
						end
					end
				end
				S_FREE: begin
					idx_q <= idx_q + CW'(1);
					if (!valid_q[idx]) begin
						slot_q <= idx;
						slot_ok_q <= 1'b1;
						state_q <= S_WRITE;
					end else if (idx_q == LastIdx) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (slot_ok_q) valid_q[slot_q] <= 1'b1;
					state_q <= S_REPLY_A;
				end
				S_REPLY_A: begin
					replied_q <= push;
					state_q <= S_REPLY_B;
				end
				S_REPLY_B: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	arpnc_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(res),
		.count(q_cnt),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dout(q_out)
	);

	assign status = q_out.status;
	assign send_opcode = q_out.send_opcode;
	assign send_sender_ip = q_out.send_sender_ip;
	assign send_target_mac = q_out.send_target_mac;
	assign send_target_ip = q_out.send_target_ip;
	assign found_mac = q_out.found_mac;
	assign purged_count = q_out.purged_count;
	assign table_full_drop = q_out.table_full_drop;
	assign last = q_out.last;
endmodule

// ===== hdl/arpnc_outq.sv =====
// Two-entry result queue between the sequencer and the output channel.
// Depends on arpnc_pkg.
module arpnc_outq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input arpnc_pkg::result_t din,
	output logic [1:0] count,
	output logic out_valid,
	input logic out_ready,
	output arpnc_pkg::result_t dout
);
	arpnc_pkg::result_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic pop;

	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== hdl/arpnc_checker.sv =====
// Port-level checks for the ARP neighbor cache responder.
// Depends on arpnc_pkg and arp_neighbor_cache_responder_core ports.
module arpnc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [3:0] status,
	input logic [1:0] send_opcode,
	input logic last
);
	a_no_accept_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted twice in a row");
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while results pending");
	a_reply_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == arpnc_pkg::ST_REPLY |-> send_opcode == arpnc_pkg::OP_REPLY)
		else $error("reply without reply opcode");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
		else $error("result changed while stalled");
endmodule

bind arp_neighbor_cache_responder_core arpnc_checker u_arpnc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.send_opcode(send_opcode),
	.last(last)
);

// ===== verif/tb_arp_neighbor_cache_responder_core.sv =====
// Testbench for the ARP neighbor cache responder: directed table plus random packets,
// ticks and lookups, checked against a behavioral cache model or typed-in values.
// Depends on arpnc_pkg and arp_neighbor_cache_responder_core.
`timescale 1ns / 100ps

module tb_arp_neighbor_cache_responder_core;
	typedef struct packed {
		logic [1:0] mode;
		logic [15:0] ethertype;
		logic [15:0] hw_type;
		logic [15:0] ptype;
		logic [7:0] hw_size;
		logic [7:0] proto_size;
		logic [15:0] opcode;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] tgt_ip;
		logic [31:0] lookup_ip;
	} arp_req_t;

	typedef struct {
		arp_req_t req;
		logic has_res;
		arpnc_pkg::result_t res;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	arp_req_t drv = '0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = arpnc_pkg::REG_MAC;
	logic [47:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 0;
	arpnc_pkg::result_t got;

	arp_neighbor_cache_responder_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(drv.mode), .ethertype(drv.ethertype), .hw_type(drv.hw_type),
		.ptype(drv.ptype), .hw_size(drv.hw_size), .proto_size(drv.proto_size),
		.opcode(drv.opcode), .src_mac(drv.src_mac), .src_ip(drv.src_ip),
		.tgt_ip(drv.tgt_ip), .lookup_ip(drv.lookup_ip),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(got.status), .send_opcode(got.send_opcode),
		.send_sender_ip(got.send_sender_ip), .send_target_mac(got.send_target_mac),
		.send_target_ip(got.send_target_ip), .found_mac(got.found_mac),
		.purged_count(got.purged_count), .table_full_drop(got.table_full_drop),
		.last(got.last)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// model of the cache and registers
	logic [47:0] m_mac;
	logic [31:0] m_ip_a, m_ip_b;
	logic [1:0] m_ip_cnt;
	logic [15:0] m_timeout;
	logic nc_valid [arpnc_pkg::TableEntries];
	logic [31:0] nc_ip [arpnc_pkg::TableEntries];
	logic [47:0] nc_mac [arpnc_pkg::TableEntries];
	logic [15:0] nc_ttl [arpnc_pkg::TableEntries];

	arpnc_pkg::result_t pending_results[$];
	int cycles = 0, mismatches = 0, results_seen = 0, reqs_sent = 0;
	bit quiet = 0;
	int in_gap = 0, out_gap = 0;
	logic [31:0] ip_pool [8];

	function automatic arpnc_pkg::result_t mk(logic [3:0] st, logic [1:0] op,
			logic [31:0] sip, logic [47:0] tmac, logic [31:0] tip, logic [47:0] fmac,
			logic [4:0] pc, logic drop, logic lst);
		arpnc_pkg::result_t r;
		r.status = st; r.send_opcode = op; r.send_sender_ip = sip;
		r.send_target_mac = tmac; r.send_target_ip = tip; r.found_mac = fmac;
		r.purged_count = pc; r.table_full_drop = drop; r.last = lst;
		return r;
	endfunction

	function automatic void cache_predict(arp_req_t q);
		int slot, n, nloc;
		logic drop;
		logic [3:0] bad;
		logic [31:0] locs [2];
		logic [4:0] purged;
		slot = -1; n = 0; drop = 0; bad = arpnc_pkg::ST_RECORDED; purged = 0;
		case (q.mode)
			arpnc_pkg::MODE_PKT: begin
				if (q.ethertype != arpnc_pkg::ETH_ARP) bad = arpnc_pkg::ST_BAD_ETH;
				else if (q.hw_type != arpnc_pkg::HW_ETH) bad = arpnc_pkg::ST_BAD_HW;
				else if (q.ptype != arpnc_pkg::PROTO_IP4) bad = arpnc_pkg::ST_BAD_PROTO;
				else if (q.hw_size != arpnc_pkg::HW_LEN) bad = arpnc_pkg::ST_BAD_HWSZ;
				else if (q.proto_size != arpnc_pkg::PROTO_LEN) bad = arpnc_pkg::ST_BAD_PRSZ;
				if (bad != arpnc_pkg::ST_RECORDED) begin
					pending_results.push_back(mk(bad, arpnc_pkg::OP_NONE, 0, 0, 0, 0, 0, 0,
						1));
					return;
				end
				for (int i = 0; i < arpnc_pkg::TableEntries; i++)
					if (slot < 0 && nc_valid[i] && nc_ip[i] == q.src_ip) slot = i;
				for (int i = 0; i < arpnc_pkg::TableEntries; i++)
					if (slot < 0 && !nc_valid[i]) slot = i;
				if (slot < 0) drop = 1;
				else begin
					nc_valid[slot] = 1; nc_ip[slot] = q.src_ip;
					nc_mac[slot] = q.src_mac; nc_ttl[slot] = m_timeout;
				end
				if (q.opcode == arpnc_pkg::ARP_REQ) begin
					locs[0] = m_ip_a; locs[1] = m_ip_b;
					nloc = (m_ip_cnt > 2) ? 2 : m_ip_cnt;
					for (int j = 0; j < nloc; j++)
						if (locs[j] == q.tgt_ip) begin
							pending_results.push_back(mk(arpnc_pkg::ST_REPLY,
								arpnc_pkg::OP_REPLY, locs[j], q.src_mac, q.src_ip,
								0, 0, drop, 0));
							n++;
						end
				end
				if (n == 0)
					pending_results.push_back(mk(arpnc_pkg::ST_RECORDED, arpnc_pkg::OP_NONE,
						0, 0, 0, 0, 0, drop, 1));
				else
					pending_results[$].last = 1;
			end
			arpnc_pkg::MODE_TICK: begin
				for (int i = 0; i < arpnc_pkg::TableEntries; i++) begin
					if (!nc_valid[i]) continue;
					if (nc_ttl[i] == 0) begin
						nc_valid[i] = 0;
						if (purged < 31) purged++;
					end else nc_ttl[i]--;
				end
				pending_results.push_back(mk(arpnc_pkg::ST_TICK, arpnc_pkg::OP_NONE, 0, 0,
					0, 0, purged, 0, 1));
			end
			arpnc_pkg::MODE_LOOKUP: begin
				for (int i = 0; i < arpnc_pkg::TableEntries; i++)
					if (slot < 0 && nc_valid[i] && nc_ip[i] == q.lookup_ip) slot = i;
				if (slot >= 0)
					pending_results.push_back(mk(arpnc_pkg::ST_HIT, arpnc_pkg::OP_NONE, 0,
						0, 0, nc_mac[slot], 0, 0, 1));
				else
					pending_results.push_back(mk(arpnc_pkg::ST_MISS, arpnc_pkg::OP_REQUEST,
						m_ip_a, '1, q.lookup_ip, 0, 0, 0, 1));
			end
			default: ;
		endcase
	endfunction

	// result sampling and sink stalls
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result %p", got);
			end else begin
				if (got !== pending_results[0]) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("result mismatch: exp %p got %p", pending_results[0], got);
				end
				void'(pending_results.pop_front());
			end
		end
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("[arp_neighbor_cache_responder_core] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (quiet) out_ready <= 1;
		else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_ready <= 0;
		end else if ($urandom_range(9) == 0) begin
			out_gap <= $urandom_range(18, 1);
			out_ready <= 0;
		end else out_ready <= 1;
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			arpnc_pkg::REG_MAC: m_mac = val;
			arpnc_pkg::REG_IP_A: m_ip_a = val[31:0];
			arpnc_pkg::REG_IP_B: m_ip_b = val[31:0];
			arpnc_pkg::REG_IP_CNT: m_ip_cnt = val[1:0];
			arpnc_pkg::REG_TIMEOUT: m_timeout = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * arpnc_pkg::TableEntries + 10) @(posedge clk);
	endtask

	task automatic send_req(arp_req_t q);
		if (!quiet && in_gap == 0 && $urandom_range(7) == 0) in_gap = $urandom_range(18, 1);
		while (in_gap > 0) begin
			@(negedge clk);
			in_gap--;
		end
		@(negedge clk);
		drv <= q;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cache_predict(q);
		reqs_sent++;
		@(negedge clk);
		in_valid <= 0;
	endtask

	function automatic arp_req_t good_pkt(logic [15:0] op, logic [47:0] smac,
			logic [31:0] sip, logic [31:0] tip);
		arp_req_t q;
		q = '0;
		q.mode = arpnc_pkg::MODE_PKT; q.ethertype = arpnc_pkg::ETH_ARP;
		q.hw_type = arpnc_pkg::HW_ETH; q.ptype = arpnc_pkg::PROTO_IP4;
		q.hw_size = arpnc_pkg::HW_LEN; q.proto_size = arpnc_pkg::PROTO_LEN;
		q.opcode = op; q.src_mac = smac; q.src_ip = sip; q.tgt_ip = tip;
		return q;
	endfunction

	function automatic arp_req_t rand_req();
		arp_req_t q;
		int pick;
		pick = $urandom_range(99);
		q = good_pkt($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2, 1)),
			{16'($urandom), 32'($urandom)}, ip_pool[$urandom_range(7)],
			ip_pool[$urandom_range(7)]);
		if ($urandom_range(3) == 0) q.src_ip = $urandom;
		q.lookup_ip = ($urandom_range(3) == 0) ? 32'($urandom) : ip_pool[$urandom_range(7)];
		if (pick < 8) begin
			case ($urandom_range(4))
				0: q.ethertype = 16'($urandom);
				1: q.hw_type = 16'($urandom);
				2: q.ptype = 16'($urandom);
				3: q.hw_size = 8'($urandom);
				default: q.proto_size = 8'($urandom);
			endcase
		end else if (pick < 20) q.mode = arpnc_pkg::MODE_TICK;
		else if (pick < 45) q.mode = arpnc_pkg::MODE_LOOKUP;
		else if (pick < 47) q.mode = arpnc_pkg::MODE_NONE;
		return q;
	endfunction

	dir_row_t dir_rows[$];
	arp_req_t tmp;

	initial begin
		m_mac = '0; m_ip_a = '0; m_ip_b = '0; m_ip_cnt = 2'd1; m_timeout = 16'd60;
		foreach (nc_valid[i]) nc_valid[i] = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// reset state: default local ip 0, miss query, empty tick
		tmp = '0; tmp.mode = arpnc_pkg::MODE_LOOKUP; tmp.lookup_ip = '1;
		dir_rows.push_back('{tmp, 1, mk(arpnc_pkg::ST_MISS, arpnc_pkg::OP_REQUEST, 0, '1,
			'1, 0, 0, 0, 1)});
		tmp = '0; tmp.mode = arpnc_pkg::MODE_TICK;
		dir_rows.push_back('{tmp, 1, mk(arpnc_pkg::ST_TICK, arpnc_pkg::OP_NONE, 0, 0, 0, 0,
			0, 0, 1)});
		tmp = good_pkt(arpnc_pkg::ARP_REQ, 0, 0, 0); tmp.ethertype = '1;
		dir_rows.push_back('{tmp, 1, mk(arpnc_pkg::ST_BAD_ETH, arpnc_pkg::OP_NONE, 0, 0, 0,
			0, 0, 0, 1)});
		tmp = good_pkt(arpnc_pkg::ARP_REQ, 0, 0, 0); tmp.hw_type = '0;
		dir_rows.push_back('{tmp, 1, mk(arpnc_pkg::ST_BAD_HW, arpnc_pkg::OP_NONE, 0, 0, 0,
			0, 0, 0, 1)});
		tmp = good_pkt(arpnc_pkg::ARP_REQ, 0, 0, 0); tmp.ptype = '1;
		dir_rows.push_back('{tmp, 1, mk(arpnc_pkg::ST_BAD_PROTO, arpnc_pkg::OP_NONE, 0, 0,
			0, 0, 0, 0, 1)});
		tmp = good_pkt(arpnc_pkg::ARP_REQ, 0, 0, 0); tmp.hw_size = '1;
		dir_rows.push_back('{tmp, 1, mk(arpnc_pkg::ST_BAD_HWSZ, arpnc_pkg::OP_NONE, 0, 0,
			0, 0, 0, 0, 1)});
		tmp = good_pkt(arpnc_pkg::ARP_REQ, 0, 0, 0); tmp.proto_size = '0;
		dir_rows.push_back('{tmp, 1, mk(arpnc_pkg::ST_BAD_PRSZ, arpnc_pkg::OP_NONE, 0, 0,
			0, 0, 0, 0, 1)});
		// request for ip 0 (local a at reset): one reply
		dir_rows.push_back('{good_pkt(arpnc_pkg::ARP_REQ, '1, '1, 0), 0, '0});
		tmp = '0; tmp.mode = arpnc_pkg::MODE_LOOKUP; tmp.lookup_ip = '1;
		dir_rows.push_back('{tmp, 1, mk(arpnc_pkg::ST_HIT, arpnc_pkg::OP_NONE, 0, 0, 0, '1,
			0, 0, 1)});
		tmp = '0; tmp.mode = arpnc_pkg::MODE_NONE; tmp.lookup_ip = '1;
		dir_rows.push_back('{tmp, 0, '0});
		dir_rows.push_back('{good_pkt(16'hFFFF, 48'h1, '1, 0), 0, '0});
		foreach (dir_rows[k]) begin
			if (dir_rows[k].has_res) begin
				send_req(dir_rows[k].req);
				// replace model expectation with the typed-in value
				pending_results[$] = dir_rows[k].res;
			end else send_req(dir_rows[k].req);
		end
		drain();

		// equal local addresses, count 3 saturating, zero timeout, fill table
		write_reg(arpnc_pkg::REG_MAC, '1);
		write_reg(arpnc_pkg::REG_IP_A, 48'h0000_C0A8_0001);
		write_reg(arpnc_pkg::REG_IP_B, 48'h0000_C0A8_0001);
		write_reg(arpnc_pkg::REG_IP_CNT, 48'd3);
		write_reg(arpnc_pkg::REG_TIMEOUT, 48'd0);
		send_req(good_pkt(arpnc_pkg::ARP_REQ, 48'h0A0B0C0D0E0F, 32'h0A00_0001,
			32'hC0A8_0001));
		tmp = '0; tmp.mode = arpnc_pkg::MODE_TICK;
		send_req(tmp);
		for (int i = 0; i < arpnc_pkg::TableEntries + 2; i++)
			send_req(good_pkt(arpnc_pkg::ARP_REQ, 48'(i), 32'h0B00_0000 + i,
				32'hC0A8_0001));
		send_req(tmp);
		send_req(tmp);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			foreach (ip_pool[i]) ip_pool[i] = (i < 3) ? 32'(i) : $urandom;
			write_reg(arpnc_pkg::REG_MAC, {16'($urandom), 32'($urandom)});
			write_reg(arpnc_pkg::REG_IP_A,
				48'(phase == 0 ? 32'h0 : (phase == 1 ? 32'hFFFF_FFFF : ip_pool[3])));
			write_reg(arpnc_pkg::REG_IP_B, 48'(ip_pool[$urandom_range(7)]));
			write_reg(arpnc_pkg::REG_IP_CNT, 48'(phase % 4));
			write_reg(arpnc_pkg::REG_TIMEOUT,
				48'(phase == 1 ? 16'hFFFF : 16'($urandom_range(6))));
			if (phase == 3) quiet = 1;
			for (int n = 0; n < 170; n++) send_req(rand_req());
			drain();
		end

		$display("covered %0d requests and checked %0d results over reset defaults",
			reqs_sent, results_seen);
		$display("and five register setups, including a full table and zero timeout");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[arp_neighbor_cache_responder_core] OK");
		else
			$display("[arp_neighbor_cache_responder_core] ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/arpnc_pkg.sv
hdl/arpnc_outq.sv
hdl/arp_neighbor_cache_responder_core.sv
hdl/arpnc_checker.sv
verif/tb_arp_neighbor_cache_responder_core.sv
